// ----- hdl/sliding_window_min_max_average_core_defines.svh -----
// ----------------------------------------------------------------------------
// sliding window min/max/average: assertion macros
// shared property wrappers for the port checker
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MIN_MAX_AVERAGE_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MIN_MAX_AVERAGE_CORE_DEFINES_SVH

// clocked property, ignored while reset is held
`define SWMMA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("swmma checker: property failed");

// property that only applies while a result is presented
`define SWMMA_ASSERT_RESULT(lbl, expr) \
    `SWMMA_ASSERT(lbl, o_out_valid |-> (expr))

`endif

// ----- hdl/swmma_pkg.sv -----
// ----------------------------------------------------------------------------
// swmma_pkg
// shared constants, types and controller/datapath command structs
// ----------------------------------------------------------------------------
package swmma_pkg;

    localparam int WINDOW    = 16;
    localparam int DATA_W    = 16;
    localparam int IDX_W     = $clog2(WINDOW);
    localparam int LIFE_W    = $clog2(WINDOW + 1);
    localparam int SUM_W     = DATA_W + IDX_W;
    localparam int AVG_SHIFT = IDX_W;

    typedef logic signed [DATA_W-1:0] t_sample;
    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [LIFE_W-1:0]        t_life;

    typedef struct packed {
        logic capture;
        logic update;
        logic rd_scan;
        t_idx scan_k;
        logic cmp_valid;
        logic cmp_first;
        t_idx cmp_k;
        logic finish;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic rescan;
    } t_status;

endpackage

// ----- hdl/swmma_ctrl.sv -----
// ----------------------------------------------------------------------------
// swmma_ctrl
// sequencer: request capture, window update, rescan sweep and result hand-off
// ----------------------------------------------------------------------------
module swmma_ctrl import swmma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    t_life      r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_cnt        = '0;
                n_state      = i_status.rescan ? S_SCAN : S_FIN;
            end
            S_SCAN: begin
                // each compare uses the store read issued in the cycle before
                if (r_cnt < LIFE_W'(WINDOW)) begin
                    o_cmd.rd_scan = 1'b1;
                    o_cmd.scan_k  = r_cnt[IDX_W-1:0];
                end
                if (r_cnt != '0) begin
                    o_cmd.cmp_valid = 1'b1;
                    o_cmd.cmp_first = (r_cnt == LIFE_W'(1));
                    o_cmd.cmp_k     = IDX_W'(r_cnt - LIFE_W'(1));
                end
                if (r_cnt == LIFE_W'(WINDOW)) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + LIFE_W'(1);
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hdl/swmma_dpath.sv -----
// ----------------------------------------------------------------------------
// swmma_dpath
// window store, running sum, extreme tracking and result registers
// ----------------------------------------------------------------------------
module swmma_dpath import swmma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_sample i_sample,
    input  t_cmd    i_cmd,
    output t_status o_status,
    output t_sample o_average,
    output t_sample o_minimum,
    output t_sample o_maximum
);

    t_sample             r_mem [WINDOW];
    logic [WINDOW-1:0]   r_vld;
    t_sample             r_rd_data;
    t_sample             r_sample;
    t_idx                r_wpos;
    t_sum                r_sum;
    t_sample             r_cur_min, r_cur_max;
    t_life               r_min_life, r_max_life;
    logic                r_min_scan, r_max_scan;
    t_sample             r_best_min, r_best_max;
    t_idx                r_kmin, r_kmax;
    t_sample             r_avg_out, r_min_out, r_max_out;

    logic [IDX_W:0]      w_back;
    t_idx                w_back_idx;
    t_idx                w_rd_addr;
    logic                w_take_min, w_take_max;
    logic                w_need_min, w_need_max;
    t_sum                w_avg;

    // entry k places back from the write position, wrapping at the window size
    always_comb begin
        w_back = {1'b0, r_wpos} + (IDX_W+1)'(WINDOW) - {1'b0, i_cmd.scan_k};
        if (w_back >= (IDX_W+1)'(WINDOW)) begin
            w_back = w_back - (IDX_W+1)'(WINDOW);
        end
        w_back_idx = w_back[IDX_W-1:0];
    end

    assign w_rd_addr  = i_cmd.capture ? r_wpos : w_back_idx;
    assign w_take_min = (r_sample <= r_cur_min);
    assign w_take_max = (r_sample >= r_cur_max);
    assign w_need_min = !w_take_min && (r_min_life <= LIFE_W'(1));
    assign w_need_max = !w_take_max && (r_max_life <= LIFE_W'(1));
    assign o_status.rescan = w_need_min || w_need_max;
    assign w_avg = r_sum >>> AVG_SHIFT;

    // window store, unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_mem[r_wpos] <= r_sample;
        end
        if (i_cmd.capture || i_cmd.rd_scan) begin
            r_rd_data <= r_vld[w_rd_addr] ? r_mem[w_rd_addr] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_wpos     <= '0;
            r_sum      <= '0;
            r_cur_min  <= '0;
            r_cur_max  <= '0;
            r_min_life <= '0;
            r_max_life <= '0;
        end else begin
            if (i_cmd.update) begin
                r_vld[r_wpos] <= 1'b1;
                // old entry arrived from the read issued at capture
                r_sum <= r_sum - SUM_W'(r_rd_data) + SUM_W'(r_sample);
                if (w_take_min) begin
                    r_cur_min  <= r_sample;
                    r_min_life <= LIFE_W'(WINDOW);
                end else if (!w_need_min) begin
                    r_min_life <= r_min_life - LIFE_W'(1);
                end
                if (w_take_max) begin
                    r_cur_max  <= r_sample;
                    r_max_life <= LIFE_W'(WINDOW);
                end else if (!w_need_max) begin
                    r_max_life <= r_max_life - LIFE_W'(1);
                end
            end
            if (i_cmd.finish) begin
                if (r_min_scan) begin
                    r_cur_min  <= r_best_min;
                    r_min_life <= LIFE_W'(WINDOW) - LIFE_W'(r_kmin);
                end
                if (r_max_scan) begin
                    r_cur_max  <= r_best_max;
                    r_max_life <= LIFE_W'(WINDOW) - LIFE_W'(r_kmax);
                end
                r_wpos <= (r_wpos == IDX_W'(WINDOW - 1)) ? '0 : r_wpos + IDX_W'(1);
            end
        end
    end

    // per-request working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
        end
        if (i_cmd.update) begin
            r_min_scan <= w_need_min;
            r_max_scan <= w_need_max;
        end
        // newest first, strict compare keeps the newest on ties
        if (i_cmd.cmp_valid) begin
            if (i_cmd.cmp_first || (r_rd_data < r_best_min)) begin
                r_best_min <= r_rd_data;
                r_kmin     <= i_cmd.cmp_k;
            end
            if (i_cmd.cmp_first || (r_rd_data > r_best_max)) begin
                r_best_max <= r_rd_data;
                r_kmax     <= i_cmd.cmp_k;
            end
        end
        if (i_cmd.load_out) begin
            r_avg_out <= w_avg[DATA_W-1:0];
            r_min_out <= r_cur_min;
            r_max_out <= r_cur_max;
        end
    end

    assign o_average = r_avg_out;
    assign o_minimum = r_min_out;
    assign o_maximum = r_max_out;

endmodule

// ----- hdl/sliding_window_min_max_average_core.sv -----
// sequence: each accepted request passes through update, finish and output hand-off;
// a rescan, one store read per window entry, runs between update and finish
// requests: one at a time; the input stalls until the result is loaded out, and
// a rescan sweeps the window store through its single read port
// reset: synchronous, active low; store reads as zero, sum, extremes and lives clear
// ----------------------------------------------------------------------------
// sliding_window_min_max_average_core
// moving average, minimum and maximum over the last window of samples
// ----------------------------------------------------------------------------
module sliding_window_min_max_average_core import swmma_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_sample i_sample,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_sample o_average,
    output t_sample o_minimum,
    output t_sample o_maximum
);

    t_cmd    w_cmd;
    t_status w_status;

    swmma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    swmma_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_sample  (i_sample),
        .i_cmd     (w_cmd),
        .o_status  (w_status),
        .o_average (o_average),
        .o_minimum (o_minimum),
        .o_maximum (o_maximum)
    );

endmodule

// ----- hdl/swmma_checker.sv -----
// ----------------------------------------------------------------------------
// swmma_checker
// port-level properties of the sliding window core, bound to the top level
// ----------------------------------------------------------------------------
`include "sliding_window_min_max_average_core_defines.svh"

module swmma_checker import swmma_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    o_in_stall,
    input t_sample i_sample,
    input logic    o_out_valid,
    input logic    i_out_stall,
    input t_sample o_average,
    input t_sample o_minimum,
    input t_sample o_maximum
);

    // the core works on one request at a time
    `SWMMA_ASSERT(a_busy_after_req, (i_in_valid && !o_in_stall) |=> o_in_stall)

    // a stalled result holds
    `SWMMA_ASSERT(a_out_hold, (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_average) && $stable(o_minimum) && $stable(o_maximum)))

    `SWMMA_ASSERT_RESULT(a_min_le_max, o_minimum <= o_maximum)

    // floor average of the window lies between its extremes
    `SWMMA_ASSERT_RESULT(a_avg_in_range, (o_average >= o_minimum) && (o_average <= o_maximum))

endmodule

bind sliding_window_min_max_average_core swmma_checker u_swmma_checker (.*);
